@@ rtl/cfq_pkg.sv @@
// Package: shared constants, operation and status codes, item and control types.
`timescale 1ns / 1ps

package cfq_pkg;

    localparam int DEPTH      = 128;
    localparam int DATA_WIDTH = 32;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        OP_PUSH  = 3'd0,
        OP_POP   = 3'd1,
        OP_FRONT = 3'd2,
        OP_BACK  = 3'd3,
        OP_CLEAR = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_RESP = 2'd2
    } state_t;

    typedef struct packed {
        op_t                          mode;
        logic signed [DATA_WIDTH-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] data;
        status_t                      status;
        logic [CNT_W-1:0]             count;
        logic                         is_empty;
        logic                         is_full;
        logic [PTR_W-1:0]             head_index;
        logic [PTR_W-1:0]             tail_index;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic exec;
    } ctrl_t;

endpackage

@@ rtl/cfq_ctrl.sv @@
// Controller: sequences one item through capture, execute and result cycles.
`timescale 1ns / 1ps

module cfq_ctrl
    import cfq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    output logic  done,
    output ctrl_t ctrl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl.load  = 1'b0;
        ctrl.exec  = 1'b0;
        busy       = 1'b1;
        done       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctrl.exec  = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/cfq_datapath.sv @@
// Datapath: slot memory, head/tail pointers, occupancy and result registers.
`timescale 1ns / 1ps

module cfq_datapath
    import cfq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  ctrl_t ctrl,
    input  cmd_t  cmd,
    output rsp_t  rsp
);

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    cmd_t                  cmd_reg;
    logic [PTR_W-1:0]      head_reg, head_next;
    logic [PTR_W-1:0]      tail_reg, tail_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    status_t               status_reg, status_next;
    logic                  rd_hit_reg;
    logic [DATA_WIDTH-1:0] rd_q_reg;

    logic                  wr_en;
    logic                  rd_en;
    logic [PTR_W-1:0]      rd_addr;
    logic                  empty_now;
    logic                  full_now;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    assign empty_now = (count_reg == '0);
    assign full_now  = (count_reg == CNT_FULL);

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        status_next = ST_OK;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = head_reg;
        unique case (cmd_reg.mode)
            OP_PUSH:
            begin
                if (full_now)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    tail_next  = ptr_inc(tail_reg);
                    count_next = count_reg + 1'b1;
                end
            end
            OP_POP:
            begin
                if (empty_now)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    rd_en      = 1'b1;
                    head_next  = ptr_inc(head_reg);
                    count_next = count_reg - 1'b1;
                end
            end
            OP_FRONT:
            begin
                if (empty_now)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    rd_en = 1'b1;
                end
            end
            OP_BACK:
            begin
                rd_addr = (tail_reg == '0) ? PTR_LAST : tail_reg - 1'b1;
                if (empty_now)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    rd_en = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                head_next  = '0;
                tail_next  = '0;
                count_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg <= cmd;
        end
        if (ctrl.exec && wr_en)
        begin
            mem[tail_reg] <= cmd_reg.value;
        end
        if (ctrl.exec && rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            status_reg <= ST_OK;
            rd_hit_reg <= 1'b0;
        end
        else if (ctrl.exec)
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            status_reg <= status_next;
            rd_hit_reg <= rd_en;
        end
    end

    assign rsp.data       = rd_hit_reg ? rd_q_reg : '0;
    assign rsp.status     = status_reg;
    assign rsp.count      = count_reg;
    assign rsp.is_empty   = (count_reg == '0);
    assign rsp.is_full    = (count_reg == CNT_FULL);
    assign rsp.head_index = head_reg;
    assign rsp.tail_index = tail_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("occupancy exceeds capacity");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == tail_reg))
        else $error("empty queue with head and tail apart");

    a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.exec && status_next != ST_OK) |=>
            (count_reg == $past(count_reg) && head_reg == $past(head_reg)
             && tail_reg == $past(tail_reg)))
        else $error("error item changed queue state");
`endif

endmodule

@@ rtl/circular_fifo_queue_core.sv @@
// Top level: ring-buffer queue of signed words, controller plus datapath.
`timescale 1ns / 1ps
// Sequence: an accepted item goes through capture, execute with slot access, and result;
//   its result is on rsp with done high in the result state.
// Items are taken only in idle, not before the last one is through; busy is high from
//   acceptance until the result cycle ends, set by the controller's execute and result states.
// Reset (rst_n low, asynchronous): head, tail and occupancy go to zero, the
//   controller returns to idle; slot contents are left as they were.
// The receiver cannot stall: done marks each result for exactly one cycle.

module circular_fifo_queue_core
    import cfq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  cmd_t cmd,
    output logic busy,
    output logic done,
    output rsp_t rsp
);

    // Command bundle from controller to datapath: capture the item, then execute it.
    ctrl_t ctrl;

    // Sequence each item: idle -> execute -> respond.
    cfq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .ctrl  (ctrl)
    );

    // Hold the slots and pointers; advance them on the execute cycle.
    cfq_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .cmd   (cmd),
        .rsp   (rsp)
    );

endmodule
